>>> design/bulk_threshold_marking_assert.svh
// Assertion shorthands for the bulk threshold marking checker.
`ifndef BULK_THRESHOLD_MARKING_ASSERT_SVH
`define BULK_THRESHOLD_MARKING_ASSERT_SVH

// Consequent in the next cycle, ignored while reset is held.
`define BTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// Consequent in the same cycle, ignored while reset is held.
`define BTM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent in the next cycle, checked during reset too.
`define BTM_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/btm_pkg.sv
`default_nettype none
package btm_pkg;
    localparam int IDX_W       = 6;
    localparam int THETA_W     = 17;
    localparam logic [THETA_W-1:0] THETA_RESET = 17'd32768;
    localparam int T2_W        = 2 * THETA_W;
    localparam int FRAC_SHIFT  = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic keep;
        logic last;
    } t_item_ctl;
endpackage
`default_nettype wire

>>> design/btm_ram.sv
`default_nettype none
module btm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> design/btm_front.sv
`default_nettype none
module btm_front #(
    parameter int MAX_COEFFS = 64,
    parameter int COEFF_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [COEFF_BITS-1:0] i_coeff,
    input  wire logic                  i_last,
    output logic                       o_q_valid,
    input  wire logic                  i_q_ready,
    output logic [COEFF_BITS-1:0]      o_q_value,
    output logic [COEFF_BITS-1:0]      o_q_mag,
    output btm_pkg::t_item_ctl         o_q_ctl
);
    localparam int CW = $clog2(MAX_COEFFS + 1);
    localparam int QD = btm_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(QD);
    localparam int FW = $clog2(QD + 1);

    logic [COEFF_BITS-1:0] r_val [QD];
    logic [COEFF_BITS-1:0] r_mag [QD];
    btm_pkg::t_item_ctl    r_ctl [QD];
    logic [PW-1:0]         r_wp, r_rp;
    logic [FW-1:0]         r_used;
    logic [CW-1:0]         r_fill;
    logic                  w_push, w_pop;
    logic [COEFF_BITS-1:0] w_mag;

    assign o_ready   = (r_used != FW'(QD));
    assign o_q_valid = (r_used != '0);
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;
    assign w_mag     = i_coeff[COEFF_BITS-1] ? (~i_coeff + 1'b1) : i_coeff;
    assign o_q_value = r_val[r_rp];
    assign o_q_mag   = r_mag[r_rp];
    assign o_q_ctl   = r_ctl[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_val[r_wp]      <= i_coeff;
            r_mag[r_wp]      <= w_mag;
            // items past a full batch are flagged for drop
            r_ctl[r_wp].keep <= (r_fill < CW'(MAX_COEFFS));
            r_ctl[r_wp].last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_used <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(QD - 1)) ? '0 : r_wp + 1'b1;
                if (i_last) begin
                    r_fill <= '0;
                end else if (r_fill < CW'(MAX_COEFFS)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_used <= r_used + 1'b1;
            end else if (w_pop && !w_push) begin
                r_used <= r_used - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

>>> design/btm_back.sv
`default_nettype none
module btm_back #(
    parameter int MAX_COEFFS = 64,
    parameter int COEFF_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [btm_pkg::THETA_W-1:0]   i_theta,
    input  wire logic                          i_q_valid,
    output logic                               o_q_ready,
    input  wire logic [COEFF_BITS-1:0]         i_q_value,
    input  wire logic [COEFF_BITS-1:0]         i_q_mag,
    input  wire btm_pkg::t_item_ctl            i_q_ctl,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [btm_pkg::IDX_W-1:0]          o_index,
    output logic [COEFF_BITS-1:0]              o_value,
    output logic                               o_last
);
    localparam int AW    = $clog2(MAX_COEFFS);
    localparam int CW    = $clog2(MAX_COEFFS + 1);
    localparam int EW    = COEFF_BITS + AW;
    localparam int SQ_W  = 2 * COEFF_BITS;
    localparam int SUM_W = SQ_W + CW;
    localparam int RHS_W = SUM_W + btm_pkg::T2_W;
    localparam int BW    = $clog2(btm_pkg::T2_W);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SQ      = 4'd1;
    localparam logic [3:0] ST_ADD     = 4'd2;
    localparam logic [3:0] ST_INS_RD  = 4'd3;
    localparam logic [3:0] ST_INS_CMP = 4'd4;
    localparam logic [3:0] ST_T2      = 4'd5;
    localparam logic [3:0] ST_MUL     = 4'd6;
    localparam logic [3:0] ST_MK_RD   = 4'd7;
    localparam logic [3:0] ST_MK_SQ   = 4'd8;
    localparam logic [3:0] ST_MK_EMIT = 4'd9;

    logic [3:0]            r_state;
    logic [CW-1:0]         r_count, r_pos, r_k;
    logic [COEFF_BITS-1:0] r_new_val, r_new_mag, r_mval;
    logic [AW-1:0]         r_midx;
    logic                  r_last;
    logic [SQ_W-1:0]       r_sq;
    logic [SUM_W-1:0]      r_sum, r_part;
    logic [btm_pkg::T2_W-1:0] r_t2;
    logic [RHS_W-1:0]      r_rhs, r_mcand;
    logic [BW-1:0]         r_bit;

    logic                  w_we;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [EW-1:0]         w_wdata, w_rdata;
    logic [COEFF_BITS-1:0] w_rd_val, w_rd_mag;
    logic [AW-1:0]         w_rd_idx;
    logic [CW-1:0]         w_pos_m1;
    logic [SUM_W-1:0]      w_part_nxt;
    logic                  w_stop, w_out_free;

    // sorted store: {value, arrival index}, descending magnitude
    btm_ram #(.WIDTH(EW), .DEPTH(MAX_COEFFS)) u_sorted (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_val   = w_rdata[EW-1:AW];
    assign w_rd_idx   = w_rdata[AW-1:0];
    assign w_rd_mag   = w_rd_val[COEFF_BITS-1] ? (~w_rd_val + 1'b1) : w_rd_val;
    assign w_pos_m1   = r_pos - 1'b1;
    assign w_part_nxt = r_part + SUM_W'(r_sq);
    assign w_stop     = (RHS_W'({w_part_nxt, {btm_pkg::FRAC_SHIFT{1'b0}}}) >= r_rhs)
                        || (CW'(r_k + 1'b1) == r_count);
    assign w_out_free = !o_valid || i_ready;
    assign o_q_ready  = (r_state == ST_IDLE);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos[AW-1:0];
        w_wdata = {r_new_val, r_count[AW-1:0]};
        w_raddr = (r_state == ST_MK_RD) ? r_k[AW-1:0] : w_pos_m1[AW-1:0];
        if (r_state == ST_INS_RD && r_pos == '0) begin
            w_we = 1'b1;
        end else if (r_state == ST_INS_CMP) begin
            w_we = 1'b1;
            if (w_rd_mag < r_new_mag) begin
                w_wdata = w_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_sum   <= '0;
            o_valid <= 1'b0;
        end else begin
            // in the emit state the output register is reloaded instead
            if (o_valid && i_ready && r_state != ST_MK_EMIT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_new_val <= i_q_value;
                        r_new_mag <= i_q_mag;
                        r_last    <= i_q_ctl.last;
                        r_pos     <= r_count;
                        if (i_q_ctl.keep) begin
                            r_state <= ST_SQ;
                        end else if (i_q_ctl.last) begin
                            r_state <= ST_T2;
                        end
                    end
                end
                ST_SQ: begin
                    r_sq    <= r_new_mag * r_new_mag;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_sum   <= r_sum + SUM_W'(r_sq);
                    r_state <= ST_INS_RD;
                end
                ST_INS_RD: begin
                    if (r_pos == '0) begin
                        r_count <= r_count + 1'b1;
                        r_state <= r_last ? ST_T2 : ST_IDLE;
                    end else begin
                        r_state <= ST_INS_CMP;
                    end
                end
                ST_INS_CMP: begin
                    if (w_rd_mag < r_new_mag) begin
                        r_pos   <= w_pos_m1;
                        r_state <= ST_INS_RD;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= r_last ? ST_T2 : ST_IDLE;
                    end
                end
                ST_T2: begin
                    r_t2    <= i_theta * i_theta;
                    r_mcand <= RHS_W'(r_sum);
                    r_rhs   <= '0;
                    r_bit   <= '0;
                    r_part  <= '0;
                    r_k     <= '0;
                    if (r_count == '0) begin
                        r_sum   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // shift-add: threshold = theta^2 * total
                    if (r_t2[0]) begin
                        r_rhs <= r_rhs + r_mcand;
                    end
                    r_t2    <= r_t2 >> 1;
                    r_mcand <= r_mcand << 1;
                    r_bit   <= r_bit + 1'b1;
                    if (r_bit == BW'(btm_pkg::T2_W - 1)) begin
                        r_state <= ST_MK_RD;
                    end
                end
                ST_MK_RD: begin
                    r_state <= ST_MK_SQ;
                end
                ST_MK_SQ: begin
                    r_mval  <= w_rd_val;
                    r_midx  <= w_rd_idx;
                    r_sq    <= w_rd_mag * w_rd_mag;
                    r_state <= ST_MK_EMIT;
                end
                ST_MK_EMIT: begin
                    if (w_out_free) begin
                        o_valid <= 1'b1;
                        o_index <= btm_pkg::IDX_W'(r_midx);
                        o_value <= r_mval;
                        o_last  <= w_stop;
                        r_part  <= w_part_nxt;
                        if (w_stop) begin
                            r_count <= '0;
                            r_sum   <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_MK_RD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/bulk_threshold_marking.sv
// Bulk threshold marking. Coefficients stream in one per item with tlast on the
// final one of a batch; up to MAX_COEFFS are kept, later ones are dropped. Each
// kept coefficient is insertion-sorted by descending magnitude into a store, one
// read and compare per entry it moves past; a two-item queue in front absorbs
// short bursts. On tlast the block forms theta^2 * total by shift-add, then
// emits marked items one at a time, each after a store read and a squaring and
// held while the output stalls (index in arrival order and value), ending with
// tlast on the item where the partial sum of squares reaches the threshold, or
// on the last stored one. While a batch is being marked the queue fills and input
// is then held off. theta (Q1.16, 65536 = 1.0) resets to 0.5; the user must
// write it only while idle, which the block itself does not enforce.
`default_nettype none
module bulk_threshold_marking #(
    parameter int MAX_COEFFS = 64,
    parameter int COEFF_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [btm_pkg::THETA_W-1:0]   i_cfg_wdata,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // [COEFF_BITS-1:0] coeff
    input  wire logic [((COEFF_BITS+7)/8)*8-1:0] i_s_tdata,
    input  wire logic                          i_s_tlast,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [5:0] marked_index, [COEFF_BITS+5:6] marked_value
    output logic [((btm_pkg::IDX_W+COEFF_BITS+7)/8)*8-1:0] o_m_tdata,
    output logic                               o_m_tlast
);
    logic [btm_pkg::THETA_W-1:0] r_theta;
    logic                        w_q_valid, w_q_ready;
    logic [COEFF_BITS-1:0]       w_q_value, w_q_mag, w_value;
    btm_pkg::t_item_ctl          w_q_ctl;
    logic [btm_pkg::IDX_W-1:0]   w_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta <= btm_pkg::THETA_RESET;
        end else if (i_cfg_we) begin
            r_theta <= i_cfg_wdata;
        end
    end

    btm_front #(.MAX_COEFFS(MAX_COEFFS), .COEFF_BITS(COEFF_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_coeff   (i_s_tdata[COEFF_BITS-1:0]),
        .i_last    (i_s_tlast),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_value (w_q_value),
        .o_q_mag   (w_q_mag),
        .o_q_ctl   (w_q_ctl)
    );

    btm_back #(.MAX_COEFFS(MAX_COEFFS), .COEFF_BITS(COEFF_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_theta   (r_theta),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_value (w_q_value),
        .i_q_mag   (w_q_mag),
        .i_q_ctl   (w_q_ctl),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_index   (w_index),
        .o_value   (w_value),
        .o_last    (o_m_tlast)
    );

    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[btm_pkg::IDX_W-1:0]            = w_index;
        o_m_tdata[btm_pkg::IDX_W +: COEFF_BITS] = w_value;
    end
endmodule
`default_nettype wire

>>> design/btm_checker.sv
`default_nettype none
`include "bulk_threshold_marking_assert.svh"
module btm_sva #(
    parameter int MAX_COEFFS = 64,
    parameter int COEFF_BITS = 24
) (
    input wire logic                                        i_clk,
    input wire logic                                        i_rst_n,
    input wire logic                                        o_m_tvalid,
    input wire logic                                        i_m_tready,
    input wire logic [((btm_pkg::IDX_W+COEFF_BITS+7)/8)*8-1:0] o_m_tdata,
    input wire logic                                        o_m_tlast
);
    logic w_stall;
    assign w_stall = o_m_tvalid && !i_m_tready;

    `BTM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, o_m_tvalid, "output dropped while stalled")
    `BTM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_stall, $stable(o_m_tdata) && $stable(o_m_tlast), "output changed while stalled")
    `BTM_ASSERT_NOW(a_index_range, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[btm_pkg::IDX_W-1:0] < MAX_COEFFS, "marked index beyond batch size")
    `BTM_ASSERT_ALWAYS_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_m_tvalid, "output valid right after reset")
endmodule

bind bulk_threshold_marking btm_sva #(
    .MAX_COEFFS(MAX_COEFFS),
    .COEFF_BITS(COEFF_BITS)
) u_btm_sva (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

>>> bench/btm_checker.sv
`default_nettype none
module btm_checker #(
    parameter int MAX_COEFFS = 64,
    parameter int COEFF_BITS = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [btm_pkg::THETA_W-1:0] i_cfg_wdata,
    input  wire logic                        i_s_tvalid,
    input  wire logic                        i_s_tready,
    input  wire logic [23:0]                 i_s_tdata,
    input  wire logic                        i_s_tlast,
    input  wire logic                        i_m_tvalid,
    input  wire logic                        i_m_tready,
    input  wire logic [31:0]                 i_m_tdata,
    input  wire logic                        i_m_tlast,
    output int                               o_errors,
    output int                               o_pending,
    output int                               o_marks_seen,
    output int                               o_batches_closed
);
    typedef struct packed {
        logic [5:0]            idx;
        logic [COEFF_BITS-1:0] value;
        logic                  last;
    } mark_t;

    logic [COEFF_BITS-1:0]       batch_coeff[MAX_COEFFS];
    logic [5:0]                  batch_order[MAX_COEFFS];
    int                          batch_count;
    logic [127:0]                batch_energy;
    logic [btm_pkg::THETA_W-1:0] theta_q;
    mark_t                       marks_due[$];

    function automatic logic [COEFF_BITS-1:0] mag_of(logic [COEFF_BITS-1:0] c);
        return c[COEFF_BITS-1] ? (~c + 1'b1) : c;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    // insert into magnitude order, then close the batch on tlast
    task automatic take_coeff(logic [COEFF_BITS-1:0] c, logic last);
        logic [127:0] part, thr2, lhs, rhs;
        logic [63:0]  m;
        int           pos, k;
        mark_t        mk;
        if (batch_count < MAX_COEFFS) begin
            m = 64'(mag_of(c));
            batch_coeff[batch_count] = c;
            pos = batch_count;
            while (pos > 0 && mag_of(batch_coeff[batch_order[pos-1]]) < mag_of(c)) begin
                batch_order[pos] = batch_order[pos-1];
                pos--;
            end
            batch_order[pos] = 6'(batch_count);
            batch_energy += 128'(m * m);
            batch_count++;
        end
        if (!last) return;
        if (batch_count > 0) o_batches_closed++;
        thr2 = 128'(theta_q) * 128'(theta_q);
        rhs  = thr2 * batch_energy;
        part = '0;
        for (k = 0; k < batch_count; k++) begin
            m = 64'(mag_of(batch_coeff[batch_order[k]]));
            part += 128'(m * m);
            lhs = part << 32;
            mk.idx   = batch_order[k];
            mk.value = batch_coeff[batch_order[k]];
            mk.last  = (lhs >= rhs) || (k + 1 == batch_count);
            marks_due.push_back(mk);
            if (mk.last) break;
        end
        batch_count  = 0;
        batch_energy = '0;
    endtask

    always @(posedge i_clk) begin
        mark_t want;
        if (!i_rst_n) begin
            batch_count  = 0;
            batch_energy = '0;
            theta_q      <= btm_pkg::THETA_RESET;
        end else begin
            if (i_cfg_we) theta_q <= i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) take_coeff(i_s_tdata[COEFF_BITS-1:0], i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                o_marks_seen++;
                if (marks_due.size() == 0) begin
                    report_mismatch("unexpected mark", 64'(i_m_tdata), 0);
                end else begin
                    want = marks_due.pop_front();
                    if (i_m_tdata[5:0] !== want.idx)
                        report_mismatch("index", 64'(i_m_tdata[5:0]), 64'(want.idx));
                    if (i_m_tdata[COEFF_BITS+5:6] !== want.value)
                        report_mismatch("value", 64'(i_m_tdata[COEFF_BITS+5:6]),
                                        64'(want.value));
                    if (i_m_tlast !== want.last)
                        report_mismatch("tlast", 64'(i_m_tlast), 64'(want.last));
                end
            end
        end
        o_pending = marks_due.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_marks_seen = 0;
        o_batches_closed = 0;
    end
endmodule
`default_nettype wire

>>> bench/tb_bulk_threshold_marking.sv
`default_nettype none
module tb_bulk_threshold_marking;
    localparam int MAXC     = 64;
    localparam int LIMIT    = 20000;
    localparam int DRAIN    = 200;

    logic                        i_clk, i_rst_n;
    logic                        i_cfg_we;
    logic [btm_pkg::THETA_W-1:0] i_cfg_wdata;
    logic                        i_s_tvalid, o_s_tready;
    logic [23:0]                 i_s_tdata;   // [23:0] coeff
    logic                        i_s_tlast;
    logic                        o_m_tvalid, i_m_tready;
    logic [31:0]                 o_m_tdata;   // [5:0] marked_index, [29:6] marked_value
    logic                        o_m_tlast;

    int  errors, pending, marks_seen, batches_closed, quiet_cycles;
    int  items_sent;
    bit  calm, hold_sink;

    bulk_threshold_marking #(.MAX_COEFFS(MAXC), .COEFF_BITS(24)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
    );

    btm_checker #(.MAX_COEFFS(MAXC), .COEFF_BITS(24)) u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tlast(o_m_tlast),
        .o_errors(errors), .o_pending(pending),
        .o_marks_seen(marks_seen), .o_batches_closed(batches_closed)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // sink: random stall bursts, none once calm is set
    initial begin
        int gap;
        i_m_tready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_sink) i_m_tready <= 0;
            else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 3);
                i_m_tready <= 0;
                repeat (gap - 1) @(posedge i_clk);
            end else i_m_tready <= 1;
        end
    end

    // watchdog on accepted items
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > LIMIT) begin
            $display("bulk_threshold_marking: mismatch");
            $finish;
        end
    end

    // tvalid stays up after an accept; the caller drops it when the stream pauses
    task automatic send_coeff(logic [23:0] c, logic last);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata  <= c;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [23:0] pick_coeff();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'(0);
            3: return 24'($urandom_range(0, 15)) - 24'd8;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_batch(int n);
        for (int k = 0; k < n; k++) send_coeff(pick_coeff(), k == n - 1);
    endtask

    task automatic settle_and_set(logic [btm_pkg::THETA_W-1:0] th);
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_wdata <= th;
        @(posedge i_clk);
        i_cfg_we    <= 0;
    endtask

    initial begin
        logic [btm_pkg::THETA_W-1:0] th;
        quiet_cycles = 0;
        items_sent = 0;
        calm = 0;
        hold_sink = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = '0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tlast = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset theta, extremes, single, ties, all-zero
        send_coeff(24'h7FFFFF, 0);
        send_coeff(24'h800000, 0);
        send_coeff(24'h000001, 0);
        send_coeff(24'hFFFFFF, 1);
        send_coeff(24'h123456, 1);
        send_coeff(24'h000010, 0);
        send_coeff(24'hFFFFF0, 0);
        send_coeff(24'h000010, 1);
        send_coeff(24'h0, 0);
        send_coeff(24'h0, 0);
        send_coeff(24'h0, 1);
        settle_and_set(17'd0);
        send_batch(5);
        settle_and_set(17'd65536);
        send_batch(6);
        settle_and_set(17'h1FFFF);
        send_batch(7);

        // overflow: 70 items, the last six are dropped
        settle_and_set(17'd50000);
        send_batch(70);

        // sink held off while marks are due and the sender keeps offering
        settle_and_set(17'd65536);
        fork
            begin
                hold_sink = 1;
                repeat (400) @(posedge i_clk);
                hold_sink = 0;
            end
            begin
                send_batch(6);
                send_batch(6);
            end
        join

        while (items_sent < 360) begin
            settle_and_set(17'($urandom_range(0, 65536)));
            repeat (4) begin
                if (items_sent > 320) calm = 1;
                send_batch($urandom_range(1, 12));
            end
        end

        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("coefficients sent: %0d, batches closed: %0d, marks checked: %0d",
                 items_sent, batches_closed, marks_seen);
        $display("covered theta 0, 0.5, 1.0, max, random; overflow, all-zero batches, "
                 , "output held off long");
        if (errors == 0) $display("bulk_threshold_marking: match");
        else $display("bulk_threshold_marking: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+design
design/btm_pkg.sv
design/btm_ram.sv
design/btm_front.sv
design/btm_back.sv
design/bulk_threshold_marking.sv
design/btm_checker.sv
bench/btm_checker.sv
bench/tb_bulk_threshold_marking.sv
